// ===== hw/rtl/mfd_pkg.sv =====
`default_nettype none

package mfd_pkg;

   localparam int unsigned LIMIT_W      = 24;
   localparam int unsigned VALUE_W      = 25;
   localparam int unsigned SID_W        = 11;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 24;
   localparam int unsigned POS_CODE_W   = 16;
   localparam int unsigned AXIS_CODE_W  = 12;
   localparam int unsigned SCALE_LATENCY = 4;

   localparam logic FUNC_FRAME = 1'b0;

   localparam logic [3:0] MIN_LENGTH = 4'd8;

   localparam logic [SID_W-1:0] ID_BASE_0 = 11'h000;
   localparam logic [SID_W-1:0] ID_BASE_1 = 11'h100;
   localparam logic [SID_W-1:0] ID_BASE_2 = 11'h200;
   localparam logic [SID_W-1:0] ID_BASE_3 = 11'h300;

   localparam logic [CSR_INDEX_W-1:0] REG_NODE_ID         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MASTER_ID       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_POSITION_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TORQUE_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFLINE_TIMEOUT = 3'd5;

   localparam logic [7:0]         RESET_NODE_ID         = 8'd1;
   localparam logic [SID_W-1:0]   RESET_MASTER_ID       = 11'd0;
   localparam logic [LIMIT_W-1:0] RESET_POSITION_LIMIT  = 24'd209715;
   localparam logic [LIMIT_W-1:0] RESET_SPEED_LIMIT     = 24'd2949120;
   localparam logic [LIMIT_W-1:0] RESET_TORQUE_LIMIT    = 24'd1179648;
   localparam logic [15:0]        RESET_OFFLINE_TIMEOUT = 16'd100;

   typedef struct packed {
      logic [7:0]         node_id;
      logic [SID_W-1:0]   master_id;
      logic [LIMIT_W-1:0] position_limit;
      logic [LIMIT_W-1:0] speed_limit;
      logic [LIMIT_W-1:0] torque_limit;
      logic [15:0]        offline_timeout;
   } cfg_type;

   typedef struct packed {
      logic        func;
      logic        frame_extended;
      logic [3:0]  frame_length;
      logic [28:0] frame_ident;
      logic [31:0] payload_high;
      logic [31:0] payload_low;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic                   accepted;
      logic [7:0]             id_fault;
      logic [POS_CODE_W-1:0]  pos_code;
      logic [AXIS_CODE_W-1:0] spd_code;
      logic [AXIS_CODE_W-1:0] trq_code;
      logic [15:0]            temps;
      logic                   online;
   } snap_type;

   typedef struct packed {
      snap_type                  snap;
      logic signed [VALUE_W-1:0] pos_value;
      logic signed [VALUE_W-1:0] spd_value;
      logic signed [VALUE_W-1:0] trq_value;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/motor_feedback_frame_decoder_core.sv =====
// channel   direction  handshake                       payload
// req_      in         push / full                     func, frame fields, time_ms
// rsp_      out        empty / pop                     accepted, ids, raw, values, temps, online
// csr_      in         valid / ready (always ready)    index, data
//
// one request per clock sustained while req_full stays low; a result shows at the earliest after
// the front queue, the four-stage constant-reciprocal scaling pipeline and the output queue.
// reset clears the registers to their defaults, the stored feedback and both queues.
// req_full rises when the front queue holds MID_DEPTH requests; the back end stops issuing
// while OUT_DEPTH results are in flight or waiting on rsp_pop.
`default_nettype none

module motor_feedback_frame_decoder_core #(
   parameter int unsigned MID_DEPTH = 4,
   parameter int unsigned OUT_DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic                                   req_func,
   input  wire logic                                   req_frame_extended,
   input  wire logic [3:0]                             req_frame_length,
   input  wire logic [28:0]                            req_frame_ident,
   input  wire logic [31:0]                            req_payload_high,
   input  wire logic [31:0]                            req_payload_low,
   input  wire logic [31:0]                            req_time_ms,

   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic                                        rsp_accepted,
   output logic [3:0]                                  rsp_reported_id,
   output logic [3:0]                                  rsp_fault_code,
   output logic signed [15:0]                          rsp_position_raw,
   output logic signed [11:0]                          rsp_speed_centered,
   output logic signed [11:0]                          rsp_torque_centered,
   output logic signed [24:0]                          rsp_position_value,
   output logic signed [24:0]                          rsp_speed_value,
   output logic signed [24:0]                          rsp_torque_value,
   output logic [7:0]                                  rsp_driver_temp,
   output logic [7:0]                                  rsp_rotor_temp,
   output logic                                        rsp_online,

   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [mfd_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [mfd_pkg::CSR_DATA_W-1:0]         csr_data
);

   mfd_pkg::cfg_type  cfg_ff, cfg_in;
   mfd_pkg::req_type  req;
   mfd_pkg::snap_type front_snap;
   mfd_pkg::snap_type mid_data;
   mfd_pkg::rsp_type  rsp_data;
   logic              front_push;
   logic              mid_full;
   logic              mid_empty;
   logic              mid_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mfd_pkg::REG_NODE_ID: begin
               cfg_in.node_id = csr_data[7:0];
            end
            mfd_pkg::REG_MASTER_ID: begin
               cfg_in.master_id = csr_data[mfd_pkg::SID_W-1:0];
            end
            mfd_pkg::REG_POSITION_LIMIT: begin
               cfg_in.position_limit = csr_data[mfd_pkg::LIMIT_W-1:0];
            end
            mfd_pkg::REG_SPEED_LIMIT: begin
               cfg_in.speed_limit = csr_data[mfd_pkg::LIMIT_W-1:0];
            end
            mfd_pkg::REG_TORQUE_LIMIT: begin
               cfg_in.torque_limit = csr_data[mfd_pkg::LIMIT_W-1:0];
            end
            mfd_pkg::REG_OFFLINE_TIMEOUT: begin
               cfg_in.offline_timeout = csr_data[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_id         <= mfd_pkg::RESET_NODE_ID;
         cfg_ff.master_id       <= mfd_pkg::RESET_MASTER_ID;
         cfg_ff.position_limit  <= mfd_pkg::RESET_POSITION_LIMIT;
         cfg_ff.speed_limit     <= mfd_pkg::RESET_SPEED_LIMIT;
         cfg_ff.torque_limit    <= mfd_pkg::RESET_TORQUE_LIMIT;
         cfg_ff.offline_timeout <= mfd_pkg::RESET_OFFLINE_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req.func           = req_func;
      req.frame_extended = req_frame_extended;
      req.frame_length   = req_frame_length;
      req.frame_ident    = req_frame_ident;
      req.payload_high   = req_payload_high;
      req.payload_low    = req_payload_low;
      req.time_ms        = req_time_ms;
   end

   mfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_push   (req_push),
      .req        (req),
      .req_full   (req_full),
      .queue_full (mid_full),
      .snap_push  (front_push),
      .snap       (front_snap)
   );

   mfd_queue #(
      .WIDTH ($bits(mfd_pkg::snap_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .data_in  (front_snap),
      .full     (mid_full),
      .pop      (mid_pop),
      .data_out (mid_data),
      .empty    (mid_empty)
   );

   mfd_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_empty (mid_empty),
      .mid_data  (mid_data),
      .mid_pop   (mid_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // raw codes are shown centered: flipping the top bit subtracts half the range
   assign rsp_accepted        = rsp_data.snap.accepted;
   assign rsp_reported_id     = rsp_data.snap.id_fault[3:0];
   assign rsp_fault_code      = rsp_data.snap.id_fault[7:4];
   assign rsp_position_raw    = signed'({~rsp_data.snap.pos_code[15], rsp_data.snap.pos_code[14:0]});
   assign rsp_speed_centered  = signed'({~rsp_data.snap.spd_code[11], rsp_data.snap.spd_code[10:0]});
   assign rsp_torque_centered = signed'({~rsp_data.snap.trq_code[11], rsp_data.snap.trq_code[10:0]});
   assign rsp_position_value  = rsp_data.pos_value;
   assign rsp_speed_value     = rsp_data.spd_value;
   assign rsp_torque_value    = rsp_data.trq_value;
   assign rsp_driver_temp     = rsp_data.snap.temps[15:8];
   assign rsp_rotor_temp      = rsp_data.snap.temps[7:0];
   assign rsp_online          = rsp_data.snap.online;

endmodule

`default_nettype wire

// ===== hw/rtl/mfd_queue.sv =====
`default_nettype none

module mfd_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] data_in,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      data_out,
   output logic                  empty
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mfd_front.sv =====
`default_nettype none

module mfd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mfd_pkg::cfg_type  cfg,
   input  wire logic              req_push,
   input  wire mfd_pkg::req_type  req,
   output logic                   req_full,
   input  wire logic              queue_full,
   output logic                   snap_push,
   output mfd_pkg::snap_type      snap
);

   logic [7:0]                      id_fault_ff, id_fault_in;
   logic [mfd_pkg::POS_CODE_W-1:0]  pos_code_ff, pos_code_in;
   logic [mfd_pkg::AXIS_CODE_W-1:0] spd_code_ff, spd_code_in;
   logic [mfd_pkg::AXIS_CODE_W-1:0] trq_code_ff, trq_code_in;
   logic [15:0]                     temps_ff, temps_in;
   logic [31:0]                     last_rx_ff, last_rx_in;
   logic                            online_ff, online_in;

   logic                            accept;
   logic                            is_frame;
   logic [mfd_pkg::SID_W-1:0]       sid;
   logic [mfd_pkg::SID_W-1:0]       node;
   logic                            id_hit;
   logic                            format_ok;
   logic                            node_ok;
   logic                            take;
   logic [31:0]                     elapsed;
   logic                            expire;

   assign req_full  = queue_full;
   assign accept    = req_push & ~queue_full;
   assign snap_push = accept;

   assign is_frame  = (req.func == mfd_pkg::FUNC_FRAME);
   assign sid       = req.frame_ident[mfd_pkg::SID_W-1:0];
   assign node      = mfd_pkg::SID_W'(cfg.node_id);
   assign id_hit    = (sid == cfg.master_id)
                   || (sid == mfd_pkg::ID_BASE_0 + node)
                   || (sid == mfd_pkg::ID_BASE_1 + node)
                   || (sid == mfd_pkg::ID_BASE_2 + node)
                   || (sid == mfd_pkg::ID_BASE_3 + node);
   assign format_ok = ~req.frame_extended && (req.frame_length >= mfd_pkg::MIN_LENGTH);
   assign node_ok   = (req.payload_high[27:24] == cfg.node_id[3:0]);
   assign take      = is_frame & format_ok & id_hit & node_ok;

   // tick: elapsed time wraps modulo 2^32
   assign elapsed = req.time_ms - last_rx_ff;
   assign expire  = ~is_frame & online_ff & (elapsed > 32'(cfg.offline_timeout));

   always_comb begin
      id_fault_in = id_fault_ff;
      pos_code_in = pos_code_ff;
      spd_code_in = spd_code_ff;
      trq_code_in = trq_code_ff;
      temps_in    = temps_ff;
      last_rx_in  = last_rx_ff;
      online_in   = online_ff;
      if (take) begin
         id_fault_in = req.payload_high[31:24];
         pos_code_in = req.payload_high[23:8];
         spd_code_in = {req.payload_high[7:0], req.payload_low[31:28]};
         trq_code_in = req.payload_low[27:16];
         temps_in    = req.payload_low[15:0];
         last_rx_in  = req.time_ms;
         online_in   = 1'b1;
      end else if (expire) begin
         online_in = 1'b0;
      end
   end

   always_comb begin
      snap.accepted = take;
      snap.id_fault = id_fault_in;
      snap.pos_code = pos_code_in;
      snap.spd_code = spd_code_in;
      snap.trq_code = trq_code_in;
      snap.temps    = temps_in;
      snap.online   = online_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_fault_ff <= '0;
         pos_code_ff <= '0;
         spd_code_ff <= '0;
         trq_code_ff <= '0;
         temps_ff    <= '0;
         last_rx_ff  <= '0;
         online_ff   <= 1'b0;
      end else if (accept) begin
         id_fault_ff <= id_fault_in;
         pos_code_ff <= pos_code_in;
         spd_code_ff <= spd_code_in;
         trq_code_ff <= trq_code_in;
         temps_ff    <= temps_in;
         last_rx_ff  <= last_rx_in;
         online_ff   <= online_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mfd_scale.sv =====
`default_nettype none

// value = round(code * 2 * limit / (2^CODE_W - 1)) - limit, four register stages
module mfd_scale #(
   parameter int unsigned CODE_W = 16
) (
   input  wire logic                                clock,
   input  wire logic [CODE_W-1:0]                   code,
   input  wire logic [mfd_pkg::LIMIT_W-1:0]         limit,
   output logic signed [mfd_pkg::VALUE_W-1:0]       value
);

   localparam int unsigned PW = CODE_W + mfd_pkg::LIMIT_W;
   localparam int unsigned MW = PW + 1;
   localparam int unsigned SW = MW + 1;
   localparam int unsigned QW = SW - CODE_W;
   localparam int unsigned RW = CODE_W + 2;
   localparam int unsigned NT = (MW + CODE_W - 1) / CODE_W;
   localparam logic [MW-1:0] HALF   = MW'((2 ** (CODE_W - 1)) - 1);
   localparam logic [RW-1:0] LEVELS = RW'((2 ** CODE_W) - 1);

   logic [PW-1:0]                   p_ff, p_in;
   logic [MW-1:0]                   m_ff, m_in;
   logic [SW-1:0]                   s_ff, s_in;
   logic [RW-1:0]                   rlo_ff;
   logic [QW-1:0]                   q_est;
   logic [RW-1:0]                   rem;
   logic [QW-1:0]                   q;
   logic [mfd_pkg::VALUE_W-1:0]     value_ff, value_in;

   assign p_in = PW'(code) * PW'(limit);
   assign m_in = {p_ff, 1'b0} + HALF;

   // m / 2^n-1 estimated by the series m>>n + m>>2n + ..., low by at most one
   always_comb begin
      s_in = '0;
      for (int k = 0; k < NT; k++) begin
         s_in = s_in + SW'(m_ff >> (k * CODE_W));
      end
   end

   assign q_est    = s_ff[SW-1:CODE_W];
   assign rem      = rlo_ff - {q_est[1:0], {CODE_W{1'b0}}} + q_est[RW-1:0];
   assign q        = q_est + QW'(rem >= LEVELS);
   assign value_in = q[mfd_pkg::VALUE_W-1:0] - mfd_pkg::VALUE_W'(limit);
   assign value    = signed'(value_ff);

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      m_ff     <= m_in;
      s_ff     <= s_in;
      rlo_ff   <= m_ff[RW-1:0];
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mfd_back.sv =====
`default_nettype none

module mfd_back #(
   parameter int unsigned OUT_DEPTH = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mfd_pkg::cfg_type   cfg,
   input  wire logic               mid_empty,
   input  wire mfd_pkg::snap_type  mid_data,
   output logic                    mid_pop,
   input  wire logic               rsp_pop,
   output logic                    rsp_empty,
   output mfd_pkg::rsp_type        rsp_data
);

   localparam int unsigned LAT = mfd_pkg::SCALE_LATENCY;
   localparam int unsigned CW  = $clog2(OUT_DEPTH + 1);

   logic [LAT-1:0]              vld_ff, vld_in;
   mfd_pkg::snap_type           snap_ff [LAT];
   logic [CW-1:0]               pending_ff, pending_in;
   logic                        issue;
   logic                        drain;
   logic                        out_full;
   mfd_pkg::rsp_type            done;
   logic signed [mfd_pkg::VALUE_W-1:0] pos_value, spd_value, trq_value;

   // results in flight plus results waiting never exceed the output queue
   assign issue   = ~mid_empty & ~out_full & (pending_ff < CW'(OUT_DEPTH));
   assign mid_pop = issue;
   assign drain   = rsp_pop & ~rsp_empty;

   assign vld_in     = {vld_ff[LAT-2:0], issue};
   assign pending_in = pending_ff + CW'(issue) - CW'(drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         pending_ff <= '0;
      end else begin
         vld_ff     <= vld_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff[0] <= mid_data;
      for (int i = 1; i < LAT; i++) begin
         snap_ff[i] <= snap_ff[i-1];
      end
   end

   mfd_scale #(.CODE_W(mfd_pkg::POS_CODE_W)) u_pos_scale (
      .clock (clock),
      .code  (mid_data.pos_code),
      .limit (cfg.position_limit),
      .value (pos_value)
   );

   mfd_scale #(.CODE_W(mfd_pkg::AXIS_CODE_W)) u_spd_scale (
      .clock (clock),
      .code  (mid_data.spd_code),
      .limit (cfg.speed_limit),
      .value (spd_value)
   );

   mfd_scale #(.CODE_W(mfd_pkg::AXIS_CODE_W)) u_trq_scale (
      .clock (clock),
      .code  (mid_data.trq_code),
      .limit (cfg.torque_limit),
      .value (trq_value)
   );

   always_comb begin
      done.snap      = snap_ff[LAT-1];
      done.pos_value = pos_value;
      done.spd_value = spd_value;
      done.trq_value = trq_value;
   end

   mfd_queue #(
      .WIDTH ($bits(mfd_pkg::rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (vld_ff[LAT-1]),
      .data_in  (done),
      .full     (out_full),
      .pop      (rsp_pop),
      .data_out (rsp_data),
      .empty    (rsp_empty)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/mfd_checker.sv =====
`default_nettype none

module mfd_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_full,
   input  wire logic                             rsp_empty,
   input  wire logic                             rsp_pop,
   input  wire logic                             rsp_accepted,
   input  wire logic signed [24:0]               rsp_position_value,
   input  wire logic signed [24:0]               rsp_torque_value,
   input  wire logic                             rsp_online
);

   // queues come out of reset empty on both sides
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // an accepted feedback frame always leaves the motor online
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_accepted |-> rsp_online)
      else $error("accepted response shows offline");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting response dropped");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_position_value) && $stable(rsp_accepted)
         && $stable(rsp_torque_value))
      else $error("waiting response changed");

endmodule

bind motor_feedback_frame_decoder_core mfd_checker u_checker (.*);

`default_nettype wire
